/* rtl/fpcb_pkg.sv */
// ============================================================================
// fpcb_pkg
// Shared types and constants for the frame profile counter bank.
// ============================================================================
package fpcb_pkg;

    localparam int unsigned MODE_W = 3;

    // bank geometry
    localparam int unsigned FEATURE_SLOTS = 32;
    localparam int unsigned HISTORY_DEPTH = 64;

    // request codes
    localparam logic [MODE_W-1:0] MODE_CPU     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DRAWS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GPU     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FRAME   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;

    localparam logic [31:0] TIME_CEILING = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  feature;
        logic [63:0] amount;
    } t_request;

    typedef struct packed {
        logic [39:0] cpu_mean;
        logic [31:0] cpu_maximum;
        logic [39:0] gpu_mean;
        logic [31:0] gpu_maximum;
        logic [39:0] calls_average;
        logic [39:0] draws_average;
        logic [6:0]  frames_in_window;
        logic        feature_known;
        logic        tracing_on;
    } t_result;

    // saturate a 64-bit time to 32 bits
    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v[63:32] != 32'd0) ? TIME_CEILING : v[31:0];
    endfunction

endpackage

/* rtl/frame_profile_counter_bank.sv */
// ============================================================================
// frame_profile_counter_bank
// Per-feature profiling counters with a per-feature frame history ring.
// ============================================================================
// Usage: drive i_req and pulse start while busy is low; the request is
// taken at that edge. Events (cpu, draws, gpu) keep busy high after
// acceptance for an accumulator read (S_EVRD) and a write-back (S_EVWR),
// so a new event is not taken until the last is written back; a readout
// request and the unused modes take effect at the accepting edge.
// A frame end while tracing walks the live features, a read and a write
// per feature, writing the history memories, then finishes in S_FRFIN.
// A frame end while not tracing goes straight to S_FRFIN, plus a clear
// sweep over all slots when tracing turns on. A query reads the feature's
// history row one entry a cycle, then runs four averages one after another
// through one 48-step bit-serial divider; an unknown feature or empty
// window skips both.
// A query produces one result on o_res, marked by o_res_valid for exactly
// one cycle; the receiver cannot stall it. Other requests produce none.
// i_cfg_we writes features_in_use at any edge; write only while idle.
// Reset clears ring cursor, fill, tracing and frame counters; accumulators
// are cleared by the sweep when tracing turns on, and history memories are
// not cleared; the block does not ensure that only written entries are read.
// ============================================================================
module frame_profile_counter_bank (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  fpcb_pkg::t_request i_req,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_data,
    output logic               o_res_valid,
    output fpcb_pkg::t_result  o_res
);
    import fpcb_pkg::*;

    localparam int unsigned FW = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;
    localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned AW = FW + HW;
    localparam int unsigned MD = FEATURE_SLOTS * HISTORY_DEPTH;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EVRD  = 10'b0000000010,
        S_EVWR  = 10'b0000000100,
        S_FRRD  = 10'b0000001000,
        S_FRWR  = 10'b0000010000,
        S_FRFIN = 10'b0000100000,
        S_CLR   = 10'b0001000000,
        S_QRD   = 10'b0010000000,
        S_QDIV  = 10'b0100000000,
        S_QOUT  = 10'b1000000000
    } t_state;

    t_state r_state;
    t_request r_req;
    logic [5:0] r_fiu;
    logic [HW-1:0] r_cursor;
    logic [CW-1:0] r_fill;
    logic r_active;
    logic [63:0] r_frame, r_reqat;
    logic [FW:0] r_idx;
    logic [CW:0] r_qcnt;
    logic r_qvalid;
    logic [1:0] r_dsel;

    // accumulator memories, one per counter kind
    logic [FW-1:0] w_acc_addr;
    logic w_acc_we;
    logic [63:0] w_cpu_wd, w_gpu_wd, w_cpu_rd, w_gpu_rd;
    logic [31:0] w_call_wd, w_draw_wd, w_call_rd, w_draw_rd;

    // history memories
    logic w_h_we;
    logic [AW-1:0] w_h_waddr, w_h_raddr;
    logic [31:0] w_hc_rd, w_hg_rd, w_hk_rd, w_hd_rd;

    // window sums and maxima
    logic [39:0] r_sc, r_sg, r_sk, r_sd;
    logic [31:0] r_mc, r_mg;
    logic [39:0] r_avg [4];

    logic [FW:0] w_live;
    logic w_known;
    logic w_div_start, w_div_done;
    logic [1:0] w_div_sel;
    logic [47:0] w_div_num;
    logic [39:0] w_div_q;
    logic [63:0] w_frame_next;
    logic w_now;

    assign w_live  = (r_fiu > 6'(FEATURE_SLOTS)) ? (FW+1)'(FEATURE_SLOTS) : (FW+1)'(r_fiu);
    assign w_known = ({1'b0, r_req.feature} < 6'(w_live)) && (r_fill != '0);
    assign busy    = (r_state != S_IDLE);
    assign w_frame_next = r_frame + 64'd1;
    assign w_now = (r_reqat + 64'd1) >= w_frame_next;

    fpcb_ram #(.WIDTH(64), .DEPTH(FEATURE_SLOTS)) u_cpu_acc (
        .i_clk, .i_we(w_acc_we), .i_waddr(w_acc_addr), .i_wdata(w_cpu_wd),
        .i_raddr(w_acc_addr), .o_rdata(w_cpu_rd));
    fpcb_ram #(.WIDTH(64), .DEPTH(FEATURE_SLOTS)) u_gpu_acc (
        .i_clk, .i_we(w_acc_we), .i_waddr(w_acc_addr), .i_wdata(w_gpu_wd),
        .i_raddr(w_acc_addr), .o_rdata(w_gpu_rd));
    fpcb_ram #(.WIDTH(32), .DEPTH(FEATURE_SLOTS)) u_call_acc (
        .i_clk, .i_we(w_acc_we), .i_waddr(w_acc_addr), .i_wdata(w_call_wd),
        .i_raddr(w_acc_addr), .o_rdata(w_call_rd));
    fpcb_ram #(.WIDTH(32), .DEPTH(FEATURE_SLOTS)) u_draw_acc (
        .i_clk, .i_we(w_acc_we), .i_waddr(w_acc_addr), .i_wdata(w_draw_wd),
        .i_raddr(w_acc_addr), .o_rdata(w_draw_rd));

    fpcb_ram #(.WIDTH(32), .DEPTH(MD)) u_cpu_hist (
        .i_clk, .i_we(w_h_we), .i_waddr(w_h_waddr), .i_wdata(sat32(w_cpu_rd)),
        .i_raddr(w_h_raddr), .o_rdata(w_hc_rd));
    fpcb_ram #(.WIDTH(32), .DEPTH(MD)) u_gpu_hist (
        .i_clk, .i_we(w_h_we), .i_waddr(w_h_waddr), .i_wdata(sat32(w_gpu_rd)),
        .i_raddr(w_h_raddr), .o_rdata(w_hg_rd));
    fpcb_ram #(.WIDTH(32), .DEPTH(MD)) u_call_hist (
        .i_clk, .i_we(w_h_we), .i_waddr(w_h_waddr), .i_wdata(w_call_rd),
        .i_raddr(w_h_raddr), .o_rdata(w_hk_rd));
    fpcb_ram #(.WIDTH(32), .DEPTH(MD)) u_draw_hist (
        .i_clk, .i_we(w_h_we), .i_waddr(w_h_waddr), .i_wdata(w_draw_rd),
        .i_raddr(w_h_raddr), .o_rdata(w_hd_rd));

    fpcb_divider u_div (
        .i_clk, .i_rst_n, .i_start(w_div_start), .i_dividend(w_div_num),
        .i_divisor(7'(r_fill)), .o_done(w_div_done), .o_quotient(w_div_q));

    // accumulator address and write data
    always_comb begin
        w_acc_addr = r_req.feature[FW-1:0];
        if (r_state == S_FRRD || r_state == S_FRWR || r_state == S_CLR) begin
            w_acc_addr = r_idx[FW-1:0];
        end
        w_acc_we  = 1'b0;
        w_cpu_wd  = w_cpu_rd;
        w_gpu_wd  = w_gpu_rd;
        w_call_wd = w_call_rd;
        w_draw_wd = w_draw_rd;
        if (r_state == S_EVWR) begin
            w_acc_we = ({1'b0, r_req.feature} < 6'(FEATURE_SLOTS));
            case (r_req.mode)
                MODE_CPU: begin
                    w_acc_we  = w_acc_we && r_active;
                    w_cpu_wd  = w_cpu_rd + r_req.amount;
                    w_call_wd = w_call_rd + 32'd1;
                end
                MODE_DRAWS: begin
                    w_acc_we  = w_acc_we && r_active;
                    w_draw_wd = w_draw_rd + r_req.amount[31:0];
                end
                MODE_GPU: w_gpu_wd = w_gpu_rd + r_req.amount;
                default: w_acc_we = 1'b0;
            endcase
        end else if (r_state == S_FRWR || r_state == S_CLR) begin
            w_acc_we  = 1'b1;
            w_cpu_wd  = '0;
            w_gpu_wd  = '0;
            w_call_wd = '0;
            w_draw_wd = '0;
        end
    end

    assign w_h_we    = (r_state == S_FRWR);
    assign w_h_waddr = {r_idx[FW-1:0], r_cursor};
    assign w_h_raddr = {r_req.feature[FW-1:0], r_qcnt[HW-1:0]};

    // divider operand select, next sum when a division ends
    assign w_div_sel = (r_state == S_QDIV) ? (r_dsel + 2'd1) : 2'd0;
    always_comb begin
        case (w_div_sel)
            2'd0: w_div_num = {r_sc, 8'd0};
            2'd1: w_div_num = {r_sg, 8'd0};
            2'd2: w_div_num = {r_sk, 8'd0};
            default: w_div_num = {r_sd, 8'd0};
        endcase
    end
    assign w_div_start = ((r_state == S_QRD) && (r_qcnt == (CW+1)'(r_fill)) && !r_qvalid)
                         || ((r_state == S_QDIV) && w_div_done && (r_dsel != 2'd3));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fiu       <= 6'd30;
            r_cursor    <= '0;
            r_fill      <= '0;
            r_active    <= 1'b0;
            r_frame     <= '0;
            r_reqat     <= '0;
            o_res_valid <= 1'b0;
            r_idx       <= '0;
            r_qcnt      <= '0;
            r_qvalid    <= 1'b0;
            r_dsel      <= '0;
        end else begin
            o_res_valid <= (r_state == S_QOUT);
            if (i_cfg_we) r_fiu <= i_cfg_data;
            case (r_state)
                S_IDLE: if (start) begin
                    r_req <= i_req;
                    r_idx <= '0;
                    case (i_req.mode)
                        MODE_CPU, MODE_DRAWS, MODE_GPU: r_state <= S_EVRD;
                        MODE_FRAME: r_state <= r_active ? S_FRRD : S_FRFIN;
                        MODE_REQUEST: r_reqat <= r_frame;
                        MODE_QUERY: begin
                            r_state  <= S_QRD;
                            r_qcnt   <= '0;
                            r_qvalid <= 1'b0;
                            r_sc <= '0; r_sg <= '0; r_sk <= '0; r_sd <= '0;
                            r_mc <= '0; r_mg <= '0;
                        end
                        default: ;
                    endcase
                end
                S_EVRD: r_state <= S_EVWR;
                S_EVWR: r_state <= S_IDLE;
                S_FRRD: begin
                    if (r_idx >= w_live) r_state <= S_FRFIN;
                    else r_state <= S_FRWR;
                end
                S_FRWR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_FRRD;
                end
                S_FRFIN: begin
                    if (r_active) begin
                        r_cursor <= (r_cursor == HW'(HISTORY_DEPTH - 1)) ? '0 : r_cursor + 1'b1;
                        if (r_fill != CW'(HISTORY_DEPTH)) r_fill <= r_fill + 1'b1;
                    end
                    r_frame  <= w_frame_next;
                    r_active <= w_now;
                    r_idx    <= '0;
                    if (w_now && !r_active) begin
                        r_cursor <= '0;
                        r_fill   <= '0;
                        r_state  <= S_CLR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (FW+1)'(FEATURE_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_QRD: begin
                    // one history entry per cycle; read data lands in the cycle after its address
                    if (r_qvalid) begin
                        r_sc <= r_sc + 40'(w_hc_rd);
                        r_sg <= r_sg + 40'(w_hg_rd);
                        r_sk <= r_sk + 40'(w_hk_rd);
                        r_sd <= r_sd + 40'(w_hd_rd);
                        if (w_hc_rd > r_mc) r_mc <= w_hc_rd;
                        if (w_hg_rd > r_mg) r_mg <= w_hg_rd;
                    end
                    if (!w_known) begin
                        r_state <= S_QOUT;
                    end else if (r_qcnt == (CW+1)'(r_fill)) begin
                        if (r_qvalid) begin
                            r_qvalid <= 1'b0;
                        end else begin
                            r_dsel  <= 2'd0;
                            r_state <= S_QDIV;
                        end
                    end else begin
                        r_qcnt   <= r_qcnt + 1'b1;
                        r_qvalid <= 1'b1;
                    end
                end
                S_QDIV: if (w_div_done) begin
                    r_avg[r_dsel] <= w_div_q;
                    r_dsel <= r_dsel + 2'd1;
                    if (r_dsel == 2'd3) r_state <= S_QOUT;
                end
                S_QOUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result word
    always_comb begin
        o_res = '0;
        o_res.frames_in_window = 7'(r_fill);
        o_res.tracing_on       = r_active;
        o_res.feature_known    = ({1'b0, r_req.feature} < 6'(w_live));
        if (w_known) begin
            o_res.cpu_mean      = r_avg[0];
            o_res.gpu_mean      = r_avg[1];
            o_res.calls_average = r_avg[2];
            o_res.draws_average = r_avg[3];
            o_res.cpu_maximum   = r_mc;
            o_res.gpu_maximum   = r_mg;
        end
    end

    // checks
    a_res_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(r_state == S_QOUT)) else $error("result outside query");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(HISTORY_DEPTH)) else $error("fill overflow");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.mode == MODE_QUERY)) |=> busy) else $error("query lost");
endmodule

/* rtl/fpcb_ram.sv */
// ============================================================================
// fpcb_ram
// Generic single-port-write, single-read RAM with registered read data.
// ============================================================================
module fpcb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/fpcb_divider.sv */
// ============================================================================
// fpcb_divider
// Restoring divider, one quotient bit per cycle, for window averages.
// ============================================================================
module fpcb_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    input  logic [6:0]  i_divisor,
    output logic        o_done,
    output logic [39:0] o_quotient
);
    logic [47:0] r_quo, n_quo;
    logic [6:0]  r_rem, n_rem;
    logic [6:0]  r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [7:0]  w_trial;

    // one shift-subtract step
    always_comb begin
        w_trial = {r_rem, r_quo[47]} - {1'b0, r_div};
        if (!w_trial[7]) begin
            n_rem = w_trial[6:0];
            n_quo = {r_quo[46:0], 1'b1};
        end else begin
            n_rem = {r_rem[5:0], r_quo[47]};
            n_quo = {r_quo[46:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == 6'd0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo[39:0];
endmodule

/* sim/frame_profile_counter_bank_tb.sv */
// ============================================================================
// frame_profile_counter_bank_tb
// Self-checking bench for the profiling counter bank. Every accepted request
// is applied to a local copy of the counters and history rings. Each query
// report is compared field by field against the predicted report. Directed
// corner cases come first, then random frames under several feature counts.
// ============================================================================
module frame_profile_counter_bank_tb;
    import fpcb_pkg::*;

    localparam int unsigned SLOTS       = FEATURE_SLOTS;
    localparam int unsigned DEPTH       = HISTORY_DEPTH;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE      = 300;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_req;
    logic     i_cfg_we;
    logic [5:0] i_cfg_data;
    logic     o_res_valid;
    t_result  o_res;

    frame_profile_counter_bank dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_res_valid(o_res_valid),
        .o_res(o_res)
    );

    // local copy of the counter bank
    logic [5:0]  feat_count;
    logic [63:0] acc_cpu   [SLOTS];
    logic [31:0] acc_calls [SLOTS];
    logic [31:0] acc_draws [SLOTS];
    logic [63:0] acc_gpu   [SLOTS];
    logic [31:0] hist_cpu  [SLOTS][DEPTH];
    logic [31:0] hist_gpu  [SLOTS][DEPTH];
    logic [31:0] hist_calls[SLOTS][DEPTH];
    logic [31:0] hist_draws[SLOTS][DEPTH];
    bit          hist_set  [SLOTS][DEPTH];
    int unsigned cursor;
    int unsigned fill;
    bit          tracing;
    logic [63:0] frame_no;
    logic [63:0] req_frame;

    t_result     pending_reports[$];
    int unsigned mismatches;
    int unsigned cycles;
    bit          no_idle;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL frame_profile_counter_bank");
            $finish;
        end
    end

    function automatic int unsigned live_count();
        return (feat_count > SLOTS) ? SLOTS : feat_count;
    endfunction

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic clear_accs();
        for (int f = 0; f < SLOTS; f++) begin
            acc_cpu[f] = '0;
            acc_calls[f] = '0;
            acc_draws[f] = '0;
            acc_gpu[f] = '0;
        end
    endtask

    // mean in q32.8 and maximum over the first fill entries
    task automatic window_stats(input int unsigned f, input int which,
                                output logic [39:0] mean, output logic [31:0] peak);
        logic [63:0] total;
        logic [31:0] v;
        total = '0;
        peak = '0;
        for (int i = 0; i < fill; i++) begin
            case (which)
                0: v = hist_cpu[f][i];
                1: v = hist_gpu[f][i];
                2: v = hist_calls[f][i];
                default: v = hist_draws[f][i];
            endcase
            total += v;
            if (v > peak) peak = v;
        end
        mean = (fill == 0) ? '0 : 40'((total << 8) / fill);
    endtask

    // apply one accepted request to the local copy
    task automatic profile_apply(input t_request r);
        t_result rep;
        logic [31:0] unused_peak;
        bit was;
        bit now;
        case (r.mode)
            MODE_CPU: if (tracing) begin
                acc_cpu[r.feature] += r.amount;
                acc_calls[r.feature] += 32'd1;
            end
            MODE_DRAWS: if (tracing) acc_draws[r.feature] += r.amount[31:0];
            MODE_GPU: acc_gpu[r.feature] += r.amount;
            MODE_FRAME: begin
                was = tracing;
                if (was) begin
                    for (int f = 0; f < live_count(); f++) begin
                        hist_cpu[f][cursor] = clip32(acc_cpu[f]);
                        hist_gpu[f][cursor] = clip32(acc_gpu[f]);
                        hist_calls[f][cursor] = acc_calls[f];
                        hist_draws[f][cursor] = acc_draws[f];
                        hist_set[f][cursor] = 1'b1;
                        acc_cpu[f] = '0;
                        acc_calls[f] = '0;
                        acc_draws[f] = '0;
                        acc_gpu[f] = '0;
                    end
                    cursor = (cursor + 1) % DEPTH;
                    fill = (fill + 1 > DEPTH) ? DEPTH : fill + 1;
                end
                frame_no = frame_no + 64'd1;
                now = (req_frame + 64'd1) >= frame_no;
                if (now && !was) begin
                    fill = 0;
                    cursor = 0;
                    clear_accs();
                end
                tracing = now;
            end
            MODE_REQUEST: req_frame = frame_no;
            MODE_QUERY: begin
                rep = '0;
                rep.feature_known = r.feature < live_count();
                if (rep.feature_known) begin
                    window_stats(r.feature, 0, rep.cpu_mean, rep.cpu_maximum);
                    window_stats(r.feature, 1, rep.gpu_mean, rep.gpu_maximum);
                    window_stats(r.feature, 2, rep.calls_average, unused_peak);
                    window_stats(r.feature, 3, rep.draws_average, unused_peak);
                end
                rep.frames_in_window = 7'(fill);
                rep.tracing_on = tracing;
                pending_reports.push_back(rep);
            end
            default: ;
        endcase
    endtask

    // a query must never cover history entries that were never written
    function automatic bit query_safe(input logic [4:0] f);
        if (f >= live_count()) return 1'b1;
        for (int i = 0; i < fill; i++)
            if (!hist_set[f][i]) return 1'b0;
        return 1'b1;
    endfunction

    // issue one request and wait for it to be taken
    task automatic send_request(input t_request r);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (r.mode == MODE_QUERY && !query_safe(r.feature)) r.mode = 3'd6;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        profile_apply(r);
    endtask

    task automatic send_fields(input logic [2:0] m, input logic [4:0] f,
                               input logic [63:0] a);
        t_request r;
        r.mode = m;
        r.feature = f;
        r.amount = a;
        send_request(r);
    endtask

    // let every report arrive and the block go quiet
    task automatic drain();
        int unsigned waited;
        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        do @(posedge i_clk); while (busy);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_feature_count(input logic [5:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        feat_count = v;
    endtask

    function automatic logic [63:0] rand_amount();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return {32'd0, $urandom};
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return 64'($urandom_range(0, 5000));
        endcase
    endfunction

    function automatic logic [4:0] rand_feature();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
    endfunction

    // report checker
    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid) begin
            if (pending_reports.size() == 0) begin
                $error("report with none expected");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("cpu_mean", want.cpu_mean, o_res.cpu_mean);
                check_field("cpu_maximum", want.cpu_maximum, o_res.cpu_maximum);
                check_field("gpu_mean", want.gpu_mean, o_res.gpu_mean);
                check_field("gpu_maximum", want.gpu_maximum, o_res.gpu_maximum);
                check_field("calls_average", want.calls_average, o_res.calls_average);
                check_field("draws_average", want.draws_average, o_res.draws_average);
                check_field("frames_in_window", want.frames_in_window,
                            o_res.frames_in_window);
                check_field("feature_known", want.feature_known, o_res.feature_known);
                check_field("tracing_on", want.tracing_on, o_res.tracing_on);
            end
        end
    end

    // corner cases: extremes, wrap, saturation, unknown features, unused modes
    task automatic test_directed();
        send_fields(MODE_QUERY, 5'd0, '0);
        send_fields(MODE_QUERY, 5'd31, '0);
        send_fields(MODE_GPU, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
        send_fields(MODE_CPU, 5'd0, 64'd7);
        send_fields(3'd6, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_fields(3'd7, 5'd2, 64'd9);
        send_fields(MODE_REQUEST, 5'd0, '0);
        send_fields(MODE_FRAME, 5'd0, '0);
        send_fields(MODE_CPU, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_fields(MODE_CPU, 5'd0, 64'd3);
        send_fields(MODE_DRAWS, 5'd0, 64'hFFFF_FFFF_0000_0005);
        send_fields(MODE_DRAWS, 5'd0, 64'h0000_0000_FFFF_FFFF);
        send_fields(MODE_GPU, 5'd1, 64'h1_0000_0000);
        send_fields(MODE_CPU, 5'd29, 64'hFFFF_FFFF);
        send_fields(MODE_REQUEST, 5'd0, '0);
        send_fields(MODE_FRAME, 5'd0, '0);
        send_fields(MODE_QUERY, 5'd0, '0);
        send_fields(MODE_QUERY, 5'd1, '0);
        send_fields(MODE_QUERY, 5'd29, '0);
        send_fields(MODE_QUERY, 5'd30, '0);
        send_fields(MODE_FRAME, 5'd0, '0);
        send_fields(MODE_QUERY, 5'd0, '0);
    endtask

    // random frames: events, a readout request most of the time, frame end, sometimes a query
    task automatic test_random_frames(input int unsigned items);
        int unsigned sent;
        int unsigned events;
        sent = 0;
        while (sent < items) begin
            events = $urandom_range(0, 6);
            repeat (events) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: send_fields(MODE_CPU, rand_feature(), rand_amount());
                    3, 4:    send_fields(MODE_DRAWS, rand_feature(), rand_amount());
                    5, 6:    send_fields(MODE_GPU, rand_feature(), rand_amount());
                    7:       send_fields(MODE_QUERY, rand_feature(), rand_amount());
                    8:       send_fields(3'($urandom_range(6, 7)), 5'($urandom),
                                         rand_amount());
                    default: send_fields(3'($urandom), 5'($urandom), rand_amount());
                endcase
            end
            if ($urandom_range(0, 9) != 0) begin
                send_fields(MODE_REQUEST, 5'($urandom), '0);
                sent++;
            end
            send_fields(MODE_FRAME, 5'($urandom), rand_amount());
            if ($urandom_range(0, 2) == 0) begin
                send_fields(MODE_QUERY, rand_feature(), rand_amount());
                sent++;
            end
            sent += events + 1;
        end
    endtask

    task automatic test_feature_counts();
        write_feature_count(6'd1);
        test_random_frames(80);
        write_feature_count(6'd63);
        test_random_frames(100);
        write_feature_count(6'd0);
        test_random_frames(40);
        write_feature_count(6'd32);
        test_random_frames(200);
        write_feature_count(6'($urandom));
        test_random_frames(100);
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        no_idle = 1'b0;
        feat_count = 6'd30;
        clear_accs();
        for (int f = 0; f < SLOTS; f++)
            for (int i = 0; i < DEPTH; i++) hist_set[f][i] = 1'b0;
        cursor = 0;
        fill = 0;
        tracing = 1'b0;
        frame_no = '0;
        req_frame = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_frames(100);
        test_feature_counts();
        drain();

        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("PASS frame_profile_counter_bank");
        end else begin
            if (pending_reports.size() != 0) $error("reports never arrived");
            $display("FAIL frame_profile_counter_bank");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/fpcb_pkg.sv
rtl/fpcb_ram.sv
rtl/fpcb_divider.sv
rtl/frame_profile_counter_bank.sv
sim/frame_profile_counter_bank_tb.sv
